// File: rtl/snc_pkg.sv
`default_nettype none

package snc_pkg;

    localparam int NUM_DIRS       = 8;
    localparam int NUM_SLOTS      = 4;
    localparam int ROW_BITS       = 12;
    localparam int WIDTH_CFG_BITS = 11;
    localparam int CFG_DATA_BITS  = 12;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CODE_BITS      = 4;
    localparam int IN_BIT_BITS    = 8;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SEEK_MINIMUM = 2'd2;

    typedef logic [CODE_BITS-1:0]   code_t;
    typedef logic [IN_BIT_BITS-1:0] in_bit_t;

    // Neighbour scan order: up-left, up, up-right, right, left, down-left, down, down-right.
    localparam int DIR_DR [NUM_DIRS] = '{-1, -1, -1, 0, 0, 1, 1, 1};
    localparam int DIR_DC [NUM_DIRS] = '{-1, 0, 1, 1, -1, -1, 0, 1};

    localparam code_t DIR_CODE [NUM_DIRS] = '{
        4'd4, 4'd3, 4'd2, 4'd1, 4'd5, 4'd6, 4'd7, 4'd8
    };
    localparam in_bit_t DIR_IN_BIT [NUM_DIRS] = '{
        8'h80, 8'h40, 8'h20, 8'h10, 8'h01, 8'h02, 8'h04, 8'h08
    };

    typedef struct packed {
        code_t   out_code;
        in_bit_t in_bit;
        logic    is_ext;
    } eval_res_t;

    // Position flags of an accepted pixel, worked out from the counters.
    typedef struct packed {
        logic r_ge1;
        logic r_ge2;
        logic c_ge1;
        logic c_ge2;
        logic c_last;
        logic r_last;
    } pos_flags_t;

    // Which of the eight directions stay inside the image.
    function automatic logic [NUM_DIRS-1:0] dir_ok(input logic up, input logic dn,
                                                  input logic lf, input logic rt);
        logic [NUM_DIRS-1:0] ok;
        ok[0] = up & lf;
        ok[1] = up;
        ok[2] = up & rt;
        ok[3] = rt;
        ok[4] = lf;
        ok[5] = dn & lf;
        ok[6] = dn;
        ok[7] = dn & rt;
        return ok;
    endfunction

endpackage

`default_nettype wire

// File: rtl/snc_line_buf.sv
`default_nettype none

module snc_line_buf #(
    parameter int DEPTH      = 1024,
    parameter int ADDR_BITS  = 10,
    parameter int DATA_BITS  = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [DATA_BITS-1:0] rd_data,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [DATA_BITS-1:0] wr_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/snc_eval.sv
`default_nettype none

module snc_eval
    import snc_pkg::*;
#(
    parameter int PIXEL_BITS = 8
) (
    input  wire logic [PIXEL_BITS-1:0]               center,
    input  wire logic [NUM_DIRS-1:0][PIXEL_BITS-1:0] nb,
    input  wire logic [NUM_DIRS-1:0]                 nb_ok,
    input  wire logic                                seek_min,
    output eval_res_t                                res
);

    function automatic logic [PIXEL_BITS-1:0] pick(input logic [PIXEL_BITS-1:0] a,
                                                   input logic [PIXEL_BITS-1:0] b,
                                                   input logic mn);
        logic take_b;
        take_b = mn ? (b < a) : (b > a);
        return take_b ? b : a;
    endfunction

    logic [NUM_DIRS-1:0][PIXEL_BITS-1:0] cand;
    logic [3:0][PIXEL_BITS-1:0]          lvl1;
    logic [1:0][PIXEL_BITS-1:0]          lvl2;
    logic [PIXEL_BITS-1:0]               ext;
    logic [NUM_DIRS-1:0]                 hit;
    logic [2:0]                          sel;

    // Out-of-image neighbours stand in as the centre, which never moves the extremum.
    always_comb begin
        for (int i = 0; i < NUM_DIRS; i++) begin
            cand[i] = nb_ok[i] ? nb[i] : center;
        end
        for (int i = 0; i < 4; i++) begin
            lvl1[i] = pick(cand[2*i], cand[2*i+1], seek_min);
        end
        for (int i = 0; i < 2; i++) begin
            lvl2[i] = pick(lvl1[2*i], lvl1[2*i+1], seek_min);
        end
        ext = pick(center, pick(lvl2[0], lvl2[1], seek_min), seek_min);
    end

    always_comb begin
        for (int i = 0; i < NUM_DIRS; i++) begin
            hit[i] = nb_ok[i] && (nb[i] == ext);
        end
        sel = 3'd0;
        for (int i = NUM_DIRS - 1; i >= 0; i--) begin
            if (hit[i]) begin
                sel = 3'(i);
            end
        end
        if ((center == ext) || (hit == '0)) begin
            res.out_code = '0;
            res.in_bit   = '0;
            res.is_ext   = 1'b1;
        end else begin
            res.out_code = DIR_CODE[sel];
            res.in_bit   = DIR_IN_BIT[3'(3'd7 - sel)];
            res.is_ext   = 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: rtl/snc_result_buf.sv
`default_nettype none

module snc_result_buf
    import snc_pkg::*;
#(
    parameter int COL_BITS = 10
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                load,
    input  wire logic [NUM_SLOTS-1:0]                load_mask,
    input  wire logic [NUM_SLOTS-1:0][ROW_BITS-1:0]  load_row,
    input  wire logic [NUM_SLOTS-1:0][COL_BITS-1:0]  load_col,
    input  wire eval_res_t [NUM_SLOTS-1:0]           load_res,
    output logic                                     free,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [ROW_BITS-1:0]                 m_row,
    output logic      [COL_BITS-1:0]                 m_col,
    output logic      [CODE_BITS-1:0]                m_out_code,
    output logic      [IN_BIT_BITS-1:0]              m_target_in_bit,
    output logic                                     m_is_extremum,
    output logic                                     m_last
);

    logic [NUM_SLOTS-1:0]               pend_reg;
    logic [NUM_SLOTS-1:0]               pend_next;
    logic [NUM_SLOTS-1:0][ROW_BITS-1:0] row_reg;
    logic [NUM_SLOTS-1:0][COL_BITS-1:0] col_reg;
    eval_res_t [NUM_SLOTS-1:0]          res_reg;
    logic [1:0]                         sel;
    logic [NUM_SLOTS-1:0]               sel_onehot;
    logic                               one_left;

    always_comb begin
        sel = 2'd0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (pend_reg[i]) begin
                sel = 2'(i);
            end
        end
        sel_onehot = '0;
        sel_onehot[sel] = 1'b1;
    end

    assign one_left = (pend_reg != '0) && ((pend_reg & (pend_reg - NUM_SLOTS'(1))) == '0);
    assign m_valid  = (pend_reg != '0);
    assign free     = (pend_reg == '0) || (m_ready && one_left);

    always_comb begin
        pend_next = pend_reg;
        if (load) begin
            pend_next = load_mask;
        end else if (m_valid && m_ready) begin
            pend_next = pend_reg & ~sel_onehot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            row_reg <= load_row;
            col_reg <= load_col;
            res_reg <= load_res;
        end
    end

    assign m_row           = row_reg[sel];
    assign m_col           = col_reg[sel];
    assign m_out_code      = res_reg[sel].out_code;
    assign m_target_in_bit = res_reg[sel].in_bit;
    assign m_is_extremum   = res_reg[sel].is_ext;
    assign m_last          = one_left;

    // A result that is not the last of its pixel always leaves another one waiting.
    a_more_after_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> m_valid)
        else $error("result buffer emptied before the last result of a pixel");

endmodule

`default_nettype wire

// File: rtl/steepest_neighbor_chain_code.sv
// Steepest-neighbour chain code for an 8-neighbour watershed arrowing pass.
//
// Pixels arrive on the s_ channel in raster order, one per transfer. For each
// pixel the block finds the maximum (or, with seek_minimum set, the minimum) of
// the pixel and its in-image neighbours, and emits on the m_ channel the chain
// code of the first neighbour in scan order that holds it, together with the
// one-hot in-code bit for that neighbour, or code 0 with is_extremum set.
// A pixel's result leaves once its lower-right neighbour has arrived, else with
// the pixel below it or, on the last row, to its right; a frame's final pixel
// releases itself. m_last marks the final result of a pixel. Results sit in a
// four-slot buffer and leave on m_ one per cycle while m_ready is high. The
// block takes one pixel per clock while m_ready stays high and each pixel
// causes at most one result; the single result port sets the rate, so a pixel
// in the last column past the first row, one on the last row past its first
// column and a frame's final pixel hold back the next pixel until their last
// result leaves. When m_ready is low the results wait in the buffer and one
// pixel more may sit in the evaluation stage; s_ready then falls. After reset the
// geometry is 640 by 480 in maximum mode and the frame starts at row 0, column 0.
// A write of image_width or image_height restarts the frame.

`default_nettype none

module steepest_neighbor_chain_code
    import snc_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // Configuration writes.
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    // Pixel stream.
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [PIXEL_BITS-1:0]     s_pixel,
    // Result stream.
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [ROW_BITS-1:0]            m_row,
    output logic [$clog2(MAX_WIDTH)-1:0]   m_col,
    output logic [CODE_BITS-1:0]           m_out_code,
    output logic [IN_BIT_BITS-1:0]         m_target_in_bit,
    output logic                           m_is_extremum,
    output logic                           m_last
);

    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int WB        = COL_BITS + 1;
    localparam int EW        = (WB > WIDTH_CFG_BITS) ? WB : WIDTH_CFG_BITS;
    localparam int RST_WIDTH = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
    localparam logic [COL_BITS-1:0] RST_WM1 = COL_BITS'(RST_WIDTH - 1);
    localparam logic [ROW_BITS-1:0] RST_HM1 = ROW_BITS'(479);

    // Effective geometry, held as last column and last row.
    logic [COL_BITS-1:0] wm1_reg;
    logic [ROW_BITS-1:0] hm1_reg;
    logic                seek_min_reg;
    logic [EW-1:0]       width_in;
    logic [EW-1:0]       width_eff;
    logic [ROW_BITS-1:0] height_in;
    logic [ROW_BITS-1:0] height_eff;
    logic                cfg_write;
    logic                geom_write;

    // Raster counters for the next pixel.
    logic [COL_BITS-1:0] col_reg;
    logic [ROW_BITS-1:0] row_reg;
    pos_flags_t          flags_now;
    logic                s_accept;

    // Evaluation stage.
    logic                  p1_valid_reg;
    logic [PIXEL_BITS-1:0] px_p1_reg;
    logic [COL_BITS-1:0]   col_p1_reg;
    logic [ROW_BITS-1:0]   row_p1_reg;
    pos_flags_t            flags_p1_reg;
    logic                  p1_advance;
    logic                  buf_free;

    logic [2*PIXEL_BITS-1:0]                lb_rd_data;
    logic [2:0][2:0][PIXEL_BITS-1:0]        win_reg;
    logic [2:0][2:0][PIXEL_BITS-1:0]        win_next;

    logic [NUM_SLOTS-1:0]                   emit_mask;
    logic [NUM_SLOTS-1:0][ROW_BITS-1:0]     emit_row;
    logic [NUM_SLOTS-1:0][COL_BITS-1:0]     emit_col;
    eval_res_t [NUM_SLOTS-1:0]              emit_res;

    // ------------------------------------------------------------------
    // Configuration. Writes are to be issued only while the block is idle; the block
    // does not enforce this. The port is always ready and a geometry write simply restarts the frame.
    // ------------------------------------------------------------------
    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign geom_write = cfg_write &&
                        ((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT));

    // Width saturates into [2, MAX_WIDTH]; height to at least 2.
    always_comb begin
        width_in = EW'(cfg_data[WIDTH_CFG_BITS-1:0]);
        if (width_in < EW'(2)) begin
            width_eff = EW'(2);
        end else if (width_in > EW'(MAX_WIDTH)) begin
            width_eff = EW'(MAX_WIDTH);
        end else begin
            width_eff = width_in;
        end
        height_in  = cfg_data[ROW_BITS-1:0];
        height_eff = (height_in < ROW_BITS'(2)) ? ROW_BITS'(2) : height_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wm1_reg      <= RST_WM1;
            hm1_reg      <= RST_HM1;
            seek_min_reg <= 1'b0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  wm1_reg      <= COL_BITS'(width_eff - EW'(1));
                REG_IMAGE_HEIGHT: hm1_reg      <= height_eff - ROW_BITS'(1);
                REG_SEEK_MINIMUM: seek_min_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input side: raster counters and the line buffer read.
    // ------------------------------------------------------------------
    assign s_ready  = !p1_valid_reg || p1_advance;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        flags_now.r_ge1  = (row_reg != '0);
        flags_now.r_ge2  = (row_reg > ROW_BITS'(1));
        flags_now.c_ge1  = (col_reg != '0);
        flags_now.c_ge2  = (col_reg > COL_BITS'(1));
        flags_now.c_last = (col_reg == wm1_reg);
        flags_now.r_last = (row_reg == hm1_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (geom_write) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_accept) begin
            if (flags_now.c_last) begin
                col_reg <= '0;
                row_reg <= flags_now.r_last ? '0 : row_reg + ROW_BITS'(1);
            end else begin
                col_reg <= col_reg + COL_BITS'(1);
            end
        end
    end

    // Each line buffer word holds the two rows above the incoming pixel: the
    // upper row in the high half and the middle row in the low half. The word
    // is rewritten after its read, once the stage moves on; the next pixel
    // always reads another column, so the two never collide.
    snc_line_buf #(
        .DEPTH     (MAX_WIDTH),
        .ADDR_BITS (COL_BITS),
        .DATA_BITS (2 * PIXEL_BITS)
    ) u_line_buf (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (col_reg),
        .rd_data (lb_rd_data),
        .wr_en   (p1_advance),
        .wr_addr (col_p1_reg),
        .wr_data ({lb_rd_data[PIXEL_BITS-1:0], px_p1_reg})
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_advance) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            px_p1_reg    <= s_pixel;
            col_p1_reg   <= col_reg;
            row_p1_reg   <= row_reg;
            flags_p1_reg <= flags_now;
        end
    end

    // ------------------------------------------------------------------
    // Evaluation stage: shift the 3x3 window and judge up to four pixels.
    // The stage moves on only when the result buffer can take its results.
    // ------------------------------------------------------------------
    assign p1_advance = p1_valid_reg && buf_free;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            win_next[k][0] = win_reg[k][1];
            win_next[k][1] = win_reg[k][2];
        end
        win_next[0][2] = lb_rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
        win_next[1][2] = lb_rd_data[PIXEL_BITS-1:0];
        win_next[2][2] = px_p1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (p1_advance) begin
            win_reg <= win_next;
        end
    end

    // Slot 0: the pixel up-left of the new one. Slot 1: the pixel above it, at
    // the end of a row. Slot 2: the pixel to the left, on the last row only.
    // Slot 3: the new pixel itself, at the end of the last row.
    assign emit_mask[0] = flags_p1_reg.r_ge1  && flags_p1_reg.c_ge1;
    assign emit_mask[1] = flags_p1_reg.r_ge1  && flags_p1_reg.c_last;
    assign emit_mask[2] = flags_p1_reg.r_last && flags_p1_reg.c_ge1;
    assign emit_mask[3] = flags_p1_reg.r_last && flags_p1_reg.c_last;

    for (genvar e = 0; e < NUM_SLOTS; e++) begin : g_slot
        localparam int CR = (e < 2) ? 1 : 2;
        localparam int CC = ((e % 2) == 0) ? 1 : 2;

        logic [NUM_DIRS-1:0][PIXEL_BITS-1:0] nb;
        logic [NUM_DIRS-1:0]                 win_ok;
        logic [NUM_DIRS-1:0]                 img_ok;
        logic                                up_ok;
        logic                                dn_ok;
        logic                                lf_ok;
        logic                                rt_ok;

        // Image borders seen from this slot's pixel; the window borders are
        // fixed and coincide with image borders wherever the slot is emitted.
        assign up_ok  = (e < 2) ? flags_p1_reg.r_ge2 : 1'b1;
        assign dn_ok  = (e < 2) ? 1'b1 : 1'b0;
        assign lf_ok  = ((e % 2) == 0) ? flags_p1_reg.c_ge2 : 1'b1;
        assign rt_ok  = ((e % 2) == 0) ? 1'b1 : 1'b0;
        assign img_ok = dir_ok(up_ok, dn_ok, lf_ok, rt_ok);

        for (genvar s = 0; s < NUM_DIRS; s++) begin : g_dir
            localparam int AR = CR + DIR_DR[s];
            localparam int AC = CC + DIR_DC[s];
            if ((AR >= 0) && (AR < 3) && (AC >= 0) && (AC < 3)) begin : g_in
                assign nb[s]     = win_next[AR][AC];
                assign win_ok[s] = 1'b1;
            end else begin : g_out
                assign nb[s]     = '0;
                assign win_ok[s] = 1'b0;
            end
        end

        snc_eval #(
            .PIXEL_BITS (PIXEL_BITS)
        ) u_eval (
            .center   (win_next[CR][CC]),
            .nb       (nb),
            .nb_ok    (img_ok & win_ok),
            .seek_min (seek_min_reg),
            .res      (emit_res[e])
        );

        assign emit_row[e] = (e < 2) ? (row_p1_reg - ROW_BITS'(1)) : row_p1_reg;
        assign emit_col[e] = ((e % 2) == 0) ? (col_p1_reg - COL_BITS'(1)) : col_p1_reg;
    end

    // ------------------------------------------------------------------
    // Result side.
    // ------------------------------------------------------------------
    snc_result_buf #(
        .COL_BITS (COL_BITS)
    ) u_result_buf (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (p1_advance),
        .load_mask       (emit_mask),
        .load_row        (emit_row),
        .load_col        (emit_col),
        .load_res        (emit_res),
        .free            (buf_free),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_row           (m_row),
        .m_col           (m_col),
        .m_out_code      (m_out_code),
        .m_target_in_bit (m_target_in_bit),
        .m_is_extremum   (m_is_extremum),
        .m_last          (m_last)
    );

    // The evaluation stage only waits while results are still pending.
    a_stall_needs_results: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && !p1_advance) |-> m_valid)
        else $error("evaluation stage stalled with an empty result buffer");

    // Every accepted pixel reaches the evaluation stage on the next edge.
    a_accept_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> p1_valid_reg)
        else $error("accepted pixel lost before evaluation");

    // The raster counters never run past the configured geometry.
    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= wm1_reg)
        else $error("column counter beyond the last column");

    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg <= hm1_reg)
        else $error("row counter beyond the last row");

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Testbench for the steepest-neighbour chain-code block.
//
// Pixels are pushed into the s_ channel in raster order. Each accepted transfer is fed
// at once into a behavioural copy of the block that keeps its own line buffers, 3x3
// window, counters and register settings. That copy works out the chain-code results
// the pixel releases and appends them to a queue. A separate process takes every
// result transfer on the m_ channel and compares it, field by field, with the oldest
// entry in that queue.
//
// Registers are only written while the block is quiet: the sender first waits until
// the queue is empty, then lets a few more cycles pass, because a pixel that releases
// no result may still be working its way through the evaluation stage.
//
// The sender works in bursts with random gaps between them. The receiver stalls on a
// rhythm of its own. Some phases switch either kind of idling off.
module tb_top;
    import snc_pkg::*;

    localparam int  CYCLE_LIMIT    = 1_200_000;
    localparam int  QUIET_CYCLES   = 20;
    localparam int  WIDE_PIXELS    = 48;
    localparam int  RANDOM_PIXELS  = 390;
    localparam int  LARGEST_WIDTH  = 1024;

    // The only index that the two-bit register port can carry beyond the defined list.
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

    // A 3x3 frame with a bright centre, a dark right neighbour and both grey extremes.
    localparam logic [71:0] RIDGE_FRAME = {
        8'd10, 8'd20,  8'd30,
        8'd40, 8'd255, 8'd0,
        8'd5,  8'd60,  8'd70
    };

    // How grey levels are drawn during a random phase.
    typedef enum int {
        GREY_FULL,
        GREY_NARROW,
        GREY_BINARY,
        GREY_FLAT
    } grey_mix_t;

    // One chain-code result, as it leaves the block.
    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [9:0]          col;
        code_t               code;
        in_bit_t             in_bit;
        logic                is_ext;
        logic                last;
    } arrow_t;

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      s_valid;
    logic                      s_ready;
    logic [7:0]                s_pixel;
    logic                      m_valid;
    logic                      m_ready;
    logic [ROW_BITS-1:0]       m_row;
    logic [9:0]                m_col;
    logic [CODE_BITS-1:0]      m_out_code;
    logic [IN_BIT_BITS-1:0]    m_target_in_bit;
    logic                      m_is_extremum;
    logic                      m_last;

    steepest_neighbor_chain_code dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel         (s_pixel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_row           (m_row),
        .m_col           (m_col),
        .m_out_code      (m_out_code),
        .m_target_in_bit (m_target_in_bit),
        .m_is_extremum   (m_is_extremum),
        .m_last          (m_last)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Behavioural copy of the block's state and its register settings.
    logic [10:0] cfg_width  = 11'd640;
    logic [11:0] cfg_height = 12'd480;
    logic        seek_min   = 1'b0;
    logic [7:0]  upper_line  [LARGEST_WIDTH];
    logic [7:0]  middle_line [LARGEST_WIDTH];
    logic [7:0]  win [3][3];
    int          row_cnt = 0;
    int          col_cnt = 0;

    // Results that the block still owes, oldest first.
    arrow_t awaited_arrows[$];

    // Run bookkeeping.
    int mismatches      = 0;
    int arrows_checked  = 0;
    int extrema_seen    = 0;
    int pixels_sent     = 0;
    int random_pixels   = 0;
    int settings_used   = 0;
    int cycles_run      = 0;

    // Idling controls, changed between phases.
    bit gaps_on    = 1'b1;
    bit stalls_on  = 1'b1;
    int burst_left = 0;
    int ready_hold = 0;

    initial begin
        foreach (upper_line[k]) begin
            upper_line[k]  = 8'd0;
            middle_line[k] = 8'd0;
        end
        foreach (win[i, j]) win[i][j] = 8'd0;
    end

    // The width saturates into the range that the line buffers can hold.
    function automatic int frame_width();
        if (cfg_width < 11'd2) return 2;
        if (cfg_width > 11'(LARGEST_WIDTH)) return LARGEST_WIDTH;
        return int'(cfg_width);
    endfunction

    // The height only saturates from below.
    function automatic int frame_height();
        return (cfg_height < 12'd2) ? 2 : int'(cfg_height);
    endfunction

    // Neighbour scan order: up-left, up, up-right, right, left, down-left, down,
    // down-right. The in-code bit is the one that the neighbour receives, so it names
    // the opposite direction.
    function automatic void scan_dir(input int s, output int dr, output int dc,
                                     output code_t code, output in_bit_t hot);
        case (s)
            0: begin dr = -1; dc = -1; code = 4'd4; hot = 8'h08; end
            1: begin dr = -1; dc =  0; code = 4'd3; hot = 8'h04; end
            2: begin dr = -1; dc =  1; code = 4'd2; hot = 8'h02; end
            3: begin dr =  0; dc =  1; code = 4'd1; hot = 8'h01; end
            4: begin dr =  0; dc = -1; code = 4'd5; hot = 8'h10; end
            5: begin dr =  1; dc = -1; code = 4'd6; hot = 8'h20; end
            6: begin dr =  1; dc =  0; code = 4'd7; hot = 8'h40; end
            default: begin dr = 1; dc = 1; code = 4'd8; hot = 8'h80; end
        endcase
    endfunction

    // Works out the arrow of the pixel held in window cell (wr, wc), which sits at
    // image position (r, c). Neighbours outside the image or the window take no part.
    function automatic arrow_t judge_pixel(input int wr, input int wc, input int r,
                                           input int c, input int w, input int h);
        int         s, dr, dc, nr, nc, ar, ac;
        logic [7:0] centre, extreme;
        logic [7:0] vals [8];
        logic [7:0] ok_mask;
        code_t      code;
        in_bit_t    hot;
        arrow_t     a;
        centre  = win[wr][wc];
        extreme = centre;
        for (s = 0; s < 8; s++) begin
            scan_dir(s, dr, dc, code, hot);
            nr = r + dr;
            nc = c + dc;
            ar = wr + dr;
            ac = wc + dc;
            ok_mask[s] = nr >= 0 && nr < h && nc >= 0 && nc < w &&
                         ar >= 0 && ar < 3 && ac >= 0 && ac < 3;
            vals[s] = 8'd0;
            if (ok_mask[s]) begin
                vals[s] = win[ar][ac];
                if (seek_min ? (vals[s] < extreme) : (vals[s] > extreme))
                    extreme = vals[s];
            end
        end
        a.row    = r[ROW_BITS-1:0];
        a.col    = c[9:0];
        a.code   = '0;
        a.in_bit = '0;
        a.is_ext = 1'b1;
        a.last   = 1'b0;
        // A pixel that already holds the extremum, a plateau included, points nowhere.
        if (centre != extreme) begin
            for (s = 0; s < 8 && a.is_ext; s++) begin
                if (ok_mask[s] && vals[s] == extreme) begin
                    scan_dir(s, dr, dc, code, hot);
                    a.code   = code;
                    a.in_bit = hot;
                    a.is_ext = 1'b0;
                end
            end
        end
        return a;
    endfunction

    // Advances the copy by one accepted pixel and queues the results it releases.
    task automatic predict_arrows(input logic [7:0] px);
        int     w, h, r, c;
        arrow_t fresh[$];
        arrow_t a;
        w = frame_width();
        h = frame_height();
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
        end
        if (row_cnt >= h) row_cnt = 0;
        r = row_cnt;
        c = col_cnt;

        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2]      = upper_line[c];
        win[1][2]      = middle_line[c];
        win[2][2]      = px;
        upper_line[c]  = middle_line[c];
        middle_line[c] = px;

        // The upper-left pixel is complete once its lower-right neighbour is here; the
        // end of a row and the last row release the pixels that have no such neighbour.
        if (r >= 1 && c >= 1)        fresh.push_back(judge_pixel(1, 1, r - 1, c - 1, w, h));
        if (r >= 1 && c == w - 1)    fresh.push_back(judge_pixel(1, 2, r - 1, c, w, h));
        if (r == h - 1 && c >= 1)    fresh.push_back(judge_pixel(2, 1, r, c - 1, w, h));
        if (r == h - 1 && c == w - 1) fresh.push_back(judge_pixel(2, 2, r, c, w, h));
        foreach (fresh[k]) begin
            a      = fresh[k];
            a.last = (k == fresh.size() - 1);
            awaited_arrows.push_back(a);
        end

        col_cnt = c + 1;
        row_cnt = r;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt = r + 1;
            if (row_cnt >= h) row_cnt = 0;
        end
    endtask

    // Offers one pixel and waits for its transfer. Valid stays high into the next call
    // unless a gap falls there, so back-to-back pixels go out without a pause.
    task automatic send_pixel(input logic [7:0] px);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = 0;
            if (gaps_on)
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_pixel <= px;
        do @(posedge aclk); while (!s_ready);
        predict_arrows(px);
        pixels_sent++;
    endtask

    // Writes one register and mirrors the write in the copy. Geometry writes restart
    // the frame; an index beyond the list changes nothing.
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_IMAGE_WIDTH: begin
                cfg_width = data[10:0];
                row_cnt   = 0;
                col_cnt   = 0;
            end
            REG_IMAGE_HEIGHT: begin
                cfg_height = data;
                row_cnt    = 0;
                col_cnt    = 0;
            end
            REG_SEEK_MINIMUM: seek_min = data[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Stops offering pixels, waits for every owed result and then for the evaluation
    // stage to empty, so that the block is idle afterwards.
    task automatic wait_until_quiet();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (awaited_arrows.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_grey(input grey_mix_t mix, input logic [7:0] level);
        case (mix)
            GREY_NARROW: return 8'($urandom_range(0, 3));
            GREY_BINARY: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            GREY_FLAT:   return level;
            default:     return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Small hand-made frames: a ridge in maximum mode, the same ridge in minimum mode,
    // an ignored write to the unused index and a flat 2x2 frame reached through
    // saturating width and height values.
    task automatic test_directed_frames();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        write_register(REG_IMAGE_WIDTH, 12'd3);
        write_register(REG_IMAGE_HEIGHT, 12'd3);
        write_register(REG_SEEK_MINIMUM, 12'd0);
        settings_used++;
        for (int k = 0; k < 9; k++) send_pixel(RIDGE_FRAME[71 - 8 * k -: 8]);
        wait_until_quiet();

        // The frame has wrapped, so the same pixels form a fresh frame in minimum mode.
        write_register(REG_SEEK_MINIMUM, 12'd1);
        write_register(REG_UNUSED, 12'hFFF);
        settings_used++;
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        for (int k = 0; k < 9; k++) send_pixel(RIDGE_FRAME[71 - 8 * k -: 8]);
        wait_until_quiet();

        write_register(REG_IMAGE_WIDTH, 12'd1);
        write_register(REG_IMAGE_HEIGHT, 12'd0);
        settings_used++;
        for (int k = 0; k < 4; k++) send_pixel(8'd128);
        wait_until_quiet();
    endtask

    // The opening stretch of a row at the largest width, reached through a width value
    // above the range that saturates. The row stays unfinished, so no result may leave.
    task automatic test_widest_row();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        write_register(REG_IMAGE_WIDTH, 12'h7FF);
        write_register(REG_IMAGE_HEIGHT, 12'd2);
        write_register(REG_SEEK_MINIMUM, 12'($urandom_range(0, 1)));
        settings_used++;
        for (int k = 0; k < WIDE_PIXELS; k++) send_pixel(8'($urandom_range(0, 255)));
        wait_until_quiet();
    endtask

    // Random phases: mostly small geometries with whole frames followed by a partial
    // one, so that frame wrap and mid-frame restarts both occur. Grey levels are drawn
    // from narrow sets often, which makes ties and plateaus common.
    task automatic test_random_frames();
        int         pick, w, h, count;
        logic [11:0] w_data, h_data;
        grey_mix_t  mix;
        logic [7:0] level;
        while (random_pixels < RANDOM_PIXELS) begin
            gaps_on   = $urandom_range(0, 3) != 0;
            stalls_on = $urandom_range(0, 3) != 0;

            // After the first phase the geometry is now and then left alone and the
            // frame carries on.
            if (random_pixels == 0 || $urandom_range(0, 4) != 0) begin
                pick = $urandom_range(0, 9);
                if (pick == 0)      w_data = 12'($urandom_range(0, 1));
                else if (pick == 1) w_data = 12'($urandom_range(9, 40));
                else                w_data = 12'($urandom_range(2, 8));
                // Bit 11 lies beyond the width register and must be dropped.
                if ($urandom_range(0, 5) == 0) w_data[11] = 1'b1;
                pick = $urandom_range(0, 9);
                if (pick == 0)      h_data = 12'($urandom_range(0, 1));
                else if (pick == 1) h_data = 12'hFFF;
                else                h_data = 12'($urandom_range(2, 5));
                if ($urandom_range(0, 1)) begin
                    write_register(REG_IMAGE_WIDTH, w_data);
                    write_register(REG_IMAGE_HEIGHT, h_data);
                end else begin
                    write_register(REG_IMAGE_HEIGHT, h_data);
                    write_register(REG_IMAGE_WIDTH, w_data);
                end
            end
            if ($urandom_range(0, 2) != 0)
                write_register(REG_SEEK_MINIMUM, 12'($urandom));
            if ($urandom_range(0, 7) == 0)
                write_register(REG_UNUSED, 12'($urandom));
            settings_used++;

            w = frame_width();
            h = frame_height();
            if (h > 50) count = w * $urandom_range(2, 6) + $urandom_range(0, w - 1);
            else        count = w * h * $urandom_range(1, 2) + $urandom_range(0, w);
            // The last phase is cut short so that the run keeps to its pixel budget.
            if (count > RANDOM_PIXELS - random_pixels) count = RANDOM_PIXELS - random_pixels;

            mix   = grey_mix_t'($urandom_range(0, 3));
            level = 8'($urandom_range(0, 255));
            for (int k = 0; k < count; k++) send_pixel(pick_grey(mix, level));
            random_pixels += count;
            wait_until_quiet();
        end
    endtask

    // Receiver rhythm: runs of readiness and short stalls, with an occasional long stall
    // that fills the result buffer and pushes back on the pixel side.
    always @(negedge aclk) begin
        if (!stalls_on) begin
            m_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold--;
        end else if (m_ready) begin
            m_ready <= 1'b0;
            ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 3);
        end else begin
            m_ready <= 1'b1;
            ready_hold = $urandom_range(0, 12);
        end
    end

    // Every result transfer is matched against the oldest owed result.
    always @(posedge aclk) begin : check_arrows
        arrow_t want, seen;
        if (aresetn && m_valid && m_ready) begin
            seen.row    = m_row;
            seen.col    = m_col;
            seen.code   = m_out_code;
            seen.in_bit = m_target_in_bit;
            seen.is_ext = m_is_extremum;
            seen.last   = m_last;
            if (awaited_arrows.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result row %0d col %0d code %0d in_bit %02h ext %0b last %0b",
                         $time, seen.row, seen.col, seen.code, seen.in_bit, seen.is_ext, seen.last);
            end else begin
                want = awaited_arrows.pop_front();
                arrows_checked++;
                if (want.is_ext) extrema_seen++;
                if (seen.row !== want.row || seen.col !== want.col || seen.code !== want.code ||
                    seen.in_bit !== want.in_bit || seen.is_ext !== want.is_ext ||
                    seen.last !== want.last) begin
                    mismatches++;
                    $display("%0t: mismatch, expected row %0d col %0d code %0d in_bit %02h ext %0b last %0b",
                             $time, want.row, want.col, want.code, want.in_bit, want.is_ext, want.last);
                    $display("%0t:           actual row %0d col %0d code %0d in_bit %02h ext %0b last %0b",
                             $time, seen.row, seen.col, seen.code, seen.in_bit, seen.is_ext, seen.last);
                end
            end
        end
    end

    // Timeout: a hung handshake ends the run here.
    initial begin : watchdog
        while (cycles_run < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles_run++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_pixel   = '0;
        m_ready   = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_frames();
        test_widest_row();
        test_random_frames();

        $display("Run covered %0d pixels over %0d register settings, maximum and minimum mode.",
                 pixels_sent, settings_used);
        $display("Checked %0d chain-code results, %0d of them local extrema, %0d mismatches.",
                 arrows_checked, extrema_seen, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
